// File: rtl/text_console_cursor_engine_assert.svh
// assertion macros for the console engine
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TCCE_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("console engine assertion failed");

// next-cycle implication, checked outside reset
`define TCCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("console engine assertion failed");

`endif

// File: rtl/tcce_pkg.sv
package tcce_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int POS_W   = (ADDR_W > 11) ? ADDR_W : 11;

  // item fields
  localparam int KIND_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 11;
  localparam int CPOS_W  = 11;
  localparam int CELL_W  = 16;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BG = 1'b1;
  localparam logic [CFG_W-1:0] FG_RESET = 4'h7;
  localparam logic [CFG_W-1:0] BG_RESET = 4'h0;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // control characters
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  // cell contents after reset: space, light grey on black
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

  // microcode step addresses
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t S_FETCH     = 4'd0;
  localparam step_t S_PUT       = 4'd1;
  localparam step_t S_RD        = 4'd2;
  localparam step_t S_RD_CAP    = 4'd3;
  localparam step_t S_CLR_INIT  = 4'd4;
  localparam step_t S_CLR_LOOP  = 4'd5;
  localparam step_t S_SCR_INIT  = 4'd6;
  localparam step_t S_SCR_LOOP  = 4'd7;
  localparam step_t S_FILL_INIT = 4'd8;
  localparam step_t S_FILL_LOOP = 4'd9;
  localparam step_t S_DONE      = 4'd10;

  typedef enum logic [1:0] {A_HOLD, A_ZERO, A_INC, A_FILL} addr_op_t;
  typedef enum logic [1:0] {C_HOLD, C_ZERO, C_PUT} cur_op_t;
  typedef enum logic [2:0] {M_NONE, M_PUT, M_READ, M_BLANK, M_COPYRD} mem_op_t;
  typedef enum logic [2:0] {
    J_TRUE, J_ACCEPT, J_SCROLL, J_MORE, J_MORE_COPY, J_OUT_BUSY
  } cond_t;

  // one control word
  typedef struct packed {
    addr_op_t addr_op;
    cur_op_t  cur_op;
    mem_op_t  mem_op;
    logic     cap;
    logic     emit;
    cond_t    cond;
    step_t    tgt_t;
    step_t    tgt_f;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic              accept;
    logic [KIND_W-1:0] kind;
    logic              scroll;
    logic              more;
    logic              more_copy;
    logic              out_busy;
  } status_t;

  // control store
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w.addr_op = A_HOLD;
    w.cur_op  = C_HOLD;
    w.mem_op  = M_NONE;
    w.cap     = 1'b0;
    w.emit    = 1'b0;
    w.cond    = J_TRUE;
    w.tgt_t   = S_FETCH;
    w.tgt_f   = S_FETCH;
    unique case (s)
      S_FETCH: begin
        w.cond  = J_ACCEPT;
        w.tgt_f = S_FETCH;
      end
      S_PUT: begin
        w.cur_op = C_PUT;
        w.mem_op = M_PUT;
        w.cond   = J_SCROLL;
        w.tgt_t  = S_SCR_INIT;
        w.tgt_f  = S_DONE;
      end
      S_RD: begin
        w.mem_op = M_READ;
        w.tgt_t  = S_RD_CAP;
      end
      S_RD_CAP: begin
        w.cap   = 1'b1;
        w.tgt_t = S_DONE;
      end
      S_CLR_INIT: begin
        w.addr_op = A_ZERO;
        w.cur_op  = C_ZERO;
        w.tgt_t   = S_CLR_LOOP;
      end
      S_CLR_LOOP: begin
        w.addr_op = A_INC;
        w.mem_op  = M_BLANK;
        w.cond    = J_MORE;
        w.tgt_t   = S_CLR_LOOP;
        w.tgt_f   = S_DONE;
      end
      S_SCR_INIT: begin
        w.addr_op = A_ZERO;
        w.tgt_t   = S_SCR_LOOP;
      end
      S_SCR_LOOP: begin
        w.addr_op = A_INC;
        w.mem_op  = M_COPYRD;
        w.cond    = J_MORE_COPY;
        w.tgt_t   = S_SCR_LOOP;
        w.tgt_f   = S_FILL_INIT;
      end
      S_FILL_INIT: begin
        w.addr_op = A_FILL;
        w.tgt_t   = S_FILL_LOOP;
      end
      S_FILL_LOOP: begin
        w.addr_op = A_INC;
        w.mem_op  = M_BLANK;
        w.cond    = J_MORE;
        w.tgt_t   = S_FILL_LOOP;
        w.tgt_f   = S_DONE;
      end
      S_DONE: begin
        w.emit  = 1'b1;
        w.cond  = J_OUT_BUSY;
        w.tgt_t = S_DONE;
        w.tgt_f = S_FETCH;
      end
      default: begin
        w.tgt_t = S_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/tcce_seq.sv
module tcce_seq (
  input  logic             clk,
  input  logic             rst,
  input  tcce_pkg::status_t st,
  output tcce_pkg::ctrl_t   ctrl
);

  tcce_pkg::step_t pc;
  tcce_pkg::step_t pc_next;
  tcce_pkg::step_t dispatch;
  logic            take;

  assign ctrl = tcce_pkg::ucode(pc);

  // entry step for each item kind
  always_comb begin
    unique case (st.kind)
      tcce_pkg::KIND_PUT:   dispatch = tcce_pkg::S_PUT;
      tcce_pkg::KIND_READ:  dispatch = tcce_pkg::S_RD;
      tcce_pkg::KIND_CLEAR: dispatch = tcce_pkg::S_CLR_INIT;
      default:              dispatch = tcce_pkg::S_DONE;
    endcase
  end

  // jump condition and next step
  always_comb begin
    unique case (ctrl.cond)
      tcce_pkg::J_TRUE:      take = 1'b1;
      tcce_pkg::J_ACCEPT:    take = st.accept;
      tcce_pkg::J_SCROLL:    take = st.scroll;
      tcce_pkg::J_MORE:      take = st.more;
      tcce_pkg::J_MORE_COPY: take = st.more_copy;
      tcce_pkg::J_OUT_BUSY:  take = st.out_busy;
      default:               take = 1'b0;
    endcase
    if (ctrl.cond == tcce_pkg::J_ACCEPT && take) begin
      pc_next = dispatch;
    end else if (take) begin
      pc_next = ctrl.tgt_t;
    end else begin
      pc_next = ctrl.tgt_f;
    end
  end

  // step counter, reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= tcce_pkg::S_CLR_INIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: rtl/text_console_cursor_engine.sv
// Text console engine: a COLUMNS x ROWS store of 16-bit cells (attribute in
// the high byte, character in the low byte) and a cursor, run by a small
// microcoded sequencer over a single-write, single-read cell memory. Each input
// item gives one result item. A clear, or a put that scrolls, walks the whole
// store, since the memory moves or blanks one cell per cycle. After reset a
// clearing pass fills the store with grey-on-black spaces and no item is
// accepted until it ends; configuration writes are taken at any time. One
// item is worked at a time; the next is taken while a finished result still
// waits in the output register.
`include "text_console_cursor_engine_assert.svh"

module text_console_cursor_engine (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_we,
  input  logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcce_pkg::CFG_W-1:0]     cfg_data,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code [7:0], cell_index [18:8]
  input  logic [1:0]  s_tuser,   // kind [1:0]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cursor_pos [10:0], cell_data [26:11]
  output logic [0:0]  m_tuser    // scrolled [0]
);

  localparam int CW = tcce_pkg::COL_W;
  localparam int RW = tcce_pkg::ROW_W;
  localparam int AW = tcce_pkg::ADDR_W;
  localparam int PW = tcce_pkg::POS_W;

  tcce_pkg::ctrl_t   ctrl;
  tcce_pkg::status_t st;

  // configuration and cursor
  logic [tcce_pkg::CFG_W-1:0] fg;
  logic [tcce_pkg::CFG_W-1:0] bg;
  logic [CW-1:0] cursor_col;
  logic [RW-1:0] cursor_row;
  logic          init_pass;

  // latched item and work registers
  logic [tcce_pkg::CHAR_W-1:0] char_q;
  logic [AW-1:0]               idx_q;
  logic                        idx_ok_q;
  logic [AW-1:0]               addr;
  logic [tcce_pkg::CELL_W-1:0] data_q;
  logic                        scrolled_q;
  logic                        copy_pend;
  logic [AW-1:0]               copy_dst;

  // result register
  logic [tcce_pkg::CPOS_W-1:0] out_pos;
  logic [tcce_pkg::CELL_W-1:0] out_data;
  logic                        out_sc;

  // cell memory
  logic [tcce_pkg::CELL_W-1:0] mem [tcce_pkg::CELLS];
  logic [tcce_pkg::CELL_W-1:0] rd_q;
  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  logic [tcce_pkg::CELL_W-1:0] mem_wd;
  logic                        mem_re;
  logic [AW-1:0]               mem_ra;

  // combinational helpers
  logic                        accept;
  logic                        load_out;
  logic [PW-1:0]               idx_ext;
  logic [PW-1:0]               pos_full;
  logic [tcce_pkg::CELL_W-1:0] blank;
  logic [CW:0]                 c1;
  logic [CW:0]                 c2;
  logic [RW:0]                 r1;
  logic [RW:0]                 r2;
  logic [CW-1:0]               wcol;
  logic                        put_we;
  logic [tcce_pkg::CELL_W-1:0] put_data;
  logic                        put_scroll;
  logic [CW-1:0]               put_col;
  logic [RW-1:0]               put_row;
  logic [AW-1:0]               put_addr;

  tcce_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .st   (st),
    .ctrl (ctrl)
  );

  // handshake and status
  assign s_tready = (ctrl.cond == tcce_pkg::J_ACCEPT);
  assign accept   = s_tvalid && s_tready;
  assign load_out = ctrl.emit && !st.out_busy && !init_pass;

  assign st.accept    = accept;
  assign st.kind      = s_tuser;
  assign st.scroll    = put_scroll;
  assign st.more      = (addr != AW'(tcce_pkg::CELLS - 1));
  assign st.more_copy = (addr != AW'(tcce_pkg::CELLS - tcce_pkg::COLUMNS - 1));
  assign st.out_busy  = m_tvalid && !m_tready;

  assign idx_ext  = PW'(s_tdata[18:8]);
  assign pos_full = PW'(cursor_row) * PW'(tcce_pkg::COLUMNS) + PW'(cursor_col);
  assign blank    = init_pass ? tcce_pkg::RESET_CELL : {bg, fg, tcce_pkg::CH_SPACE};

  // put: cursor motion and the cell it writes
  always_comb begin
    c1       = {1'b0, cursor_col};
    r1       = {1'b0, cursor_row};
    wcol     = cursor_col;
    put_we   = 1'b0;
    put_data = {bg, fg, char_q};
    unique case (char_q)
      tcce_pkg::CH_LF: begin
        c1 = '0;
        r1 = {1'b0, cursor_row} + (RW+1)'(1);
      end
      tcce_pkg::CH_CR: begin
        c1 = '0;
      end
      tcce_pkg::CH_TAB: begin
        c1 = ({1'b0, cursor_col} + (CW+1)'(8)) & ~((CW+1)'(7));
      end
      tcce_pkg::CH_BS: begin
        if (cursor_col != '0) begin
          c1       = {1'b0, cursor_col} - (CW+1)'(1);
          wcol     = cursor_col - CW'(1);
          put_we   = 1'b1;
          put_data = {bg, fg, tcce_pkg::CH_SPACE};
        end
      end
      default: begin
        put_we = 1'b1;
        c1     = {1'b0, cursor_col} + (CW+1)'(1);
      end
    endcase
    // wrap past the last column
    if (c1 >= (CW+1)'(tcce_pkg::COLUMNS)) begin
      c2 = '0;
      r2 = r1 + (RW+1)'(1);
    end else begin
      c2 = c1;
      r2 = r1;
    end
    // scroll past the last row
    put_scroll = (r2 >= (RW+1)'(tcce_pkg::ROWS));
    put_col    = c2[CW-1:0];
    put_row    = put_scroll ? RW'(tcce_pkg::ROWS - 1) : r2[RW-1:0];
    put_addr   = AW'(cursor_row) * AW'(tcce_pkg::COLUMNS) + AW'(wcol);
  end

  // memory port selection; a pending scroll copy owns the write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr;
    mem_wd = blank;
    mem_re = 1'b0;
    mem_ra = idx_q;
    if (copy_pend) begin
      mem_we = 1'b1;
      mem_wa = copy_dst;
      mem_wd = rd_q;
    end
    unique case (ctrl.mem_op)
      tcce_pkg::M_PUT: begin
        mem_we = put_we;
        mem_wa = put_addr;
        mem_wd = put_data;
      end
      tcce_pkg::M_BLANK: begin
        mem_we = 1'b1;
        mem_wa = addr;
        mem_wd = blank;
      end
      tcce_pkg::M_READ: begin
        mem_re = 1'b1;
        mem_ra = idx_q;
      end
      tcce_pkg::M_COPYRD: begin
        mem_re = 1'b1;
        mem_ra = addr + AW'(tcce_pkg::COLUMNS);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= tcce_pkg::FG_RESET;
      bg <= tcce_pkg::BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcce_pkg::REG_FG: fg <= cfg_data;
        tcce_pkg::REG_BG: bg <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // item latch, address counter and result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      char_q     <= s_tdata[7:0];
      idx_q      <= idx_ext[AW-1:0];
      idx_ok_q   <= (idx_ext < PW'(tcce_pkg::CELLS));
      data_q     <= '0;
      scrolled_q <= 1'b0;
    end
    if (ctrl.cap) begin
      data_q <= idx_ok_q ? rd_q : '0;
    end
    if (ctrl.cur_op == tcce_pkg::C_PUT) begin
      scrolled_q <= put_scroll;
    end
    unique case (ctrl.addr_op)
      tcce_pkg::A_ZERO: addr <= '0;
      tcce_pkg::A_INC:  addr <= addr + AW'(1);
      tcce_pkg::A_FILL: addr <= AW'(tcce_pkg::CELLS - tcce_pkg::COLUMNS);
      default: begin
      end
    endcase
    copy_dst <= addr;
  end

  // cursor, copy pipeline and init flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      copy_pend  <= 1'b0;
      init_pass  <= 1'b1;
    end else begin
      copy_pend <= (ctrl.mem_op == tcce_pkg::M_COPYRD);
      unique case (ctrl.cur_op)
        tcce_pkg::C_ZERO: begin
          cursor_col <= '0;
          cursor_row <= '0;
        end
        tcce_pkg::C_PUT: begin
          cursor_col <= put_col;
          cursor_row <= put_row;
        end
        default: begin
        end
      endcase
      if (ctrl.emit && init_pass) begin
        init_pass <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pos  <= pos_full[tcce_pkg::CPOS_W-1:0];
      out_data <= data_q;
      out_sc   <= scrolled_q;
    end
  end

  assign m_tdata = {5'b0, out_data, out_pos};
  assign m_tuser = out_sc;

  // no item is taken before the store is cleared
  `TCCE_ASSERT(a_init_blocks, init_pass, !s_tready)
  // a scroll copy never meets another write
  `TCCE_ASSERT(a_copy_alone, copy_pend, ctrl.mem_op != tcce_pkg::M_PUT && ctrl.mem_op != tcce_pkg::M_BLANK)
  // cursor stays on the screen
  `TCCE_ASSERT(a_cursor_range, 1'b1, cursor_col < CW'(tcce_pkg::COLUMNS) && (RW+1)'(cursor_row) < (RW+1)'(tcce_pkg::ROWS))
  // one item at a time
  `TCCE_ASSERT_NEXT(a_one_item, accept, !s_tready)

endmodule

// File: test/text_console_cursor_engine_tb.sv
`timescale 1ns / 1ps

module text_console_cursor_engine_tb;

  // kind value with no operation behind it
  localparam logic [tcce_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned TAB_STOP = 8;
  localparam int MAX_SHOWN = 10;

  // one result item as the console reports it
  typedef struct packed {
    logic [tcce_pkg::CPOS_W-1:0] cursor_pos;
    logic [tcce_pkg::CELL_W-1:0] cell_data;
    logic                        scrolled;
  } report_t;

  // console model: screen, cursor, colors, and the reports still owed
  class console_scoreboard;
    logic [tcce_pkg::CELL_W-1:0] cells [tcce_pkg::CELLS];
    int unsigned col;
    int unsigned row;
    logic [tcce_pkg::CFG_W-1:0] fg;
    logic [tcce_pkg::CFG_W-1:0] bg;
    report_t pending[$];
    int failures;

    function new();
      fg = tcce_pkg::FG_RESET;
      bg = tcce_pkg::BG_RESET;
      failures = 0;
      foreach (cells[i]) cells[i] = tcce_pkg::RESET_CELL;
      col = 0;
      row = 0;
    endfunction

    function logic [tcce_pkg::CELL_W-1:0] attr_cell(logic [tcce_pkg::CHAR_W-1:0] ch);
      return {bg, fg, ch};
    endfunction

    function void blank_screen();
      foreach (cells[i]) cells[i] = attr_cell(tcce_pkg::CH_SPACE);
      col = 0;
      row = 0;
    endfunction

    function void set_reg(logic [tcce_pkg::CFG_IDX_W-1:0] idx,
                          logic [tcce_pkg::CFG_W-1:0] val);
      if (idx == tcce_pkg::REG_FG) fg = val;
      else if (idx == tcce_pkg::REG_BG) bg = val;
    endfunction

    // advance the console by one accepted item and queue its report
    function void apply_item(logic [tcce_pkg::KIND_W-1:0] kind,
                             logic [tcce_pkg::CHAR_W-1:0] ch,
                             logic [tcce_pkg::IDX_W-1:0] idx);
      report_t r;
      int unsigned i;
      r.cell_data = '0;
      r.scrolled  = 1'b0;
      case (kind)
        tcce_pkg::KIND_PUT: begin
          if (ch == tcce_pkg::CH_LF) begin
            col = 0;
            row++;
          end else if (ch == tcce_pkg::CH_CR) begin
            col = 0;
          end else if (ch == tcce_pkg::CH_TAB) begin
            col = (col + TAB_STOP) & ~(TAB_STOP - 1);
          end else if (ch == tcce_pkg::CH_BS) begin
            if (col > 0) begin
              col--;
              cells[row * tcce_pkg::COLUMNS + col] = attr_cell(tcce_pkg::CH_SPACE);
            end
          end else begin
            cells[row * tcce_pkg::COLUMNS + col] = attr_cell(ch);
            col++;
          end
          // wrap past the last column
          if (col >= tcce_pkg::COLUMNS) begin
            col = 0;
            row++;
          end
          // scroll up one line past the last row
          if (row >= tcce_pkg::ROWS) begin
            for (i = 0; i + tcce_pkg::COLUMNS < tcce_pkg::CELLS; i++)
              cells[i] = cells[i + tcce_pkg::COLUMNS];
            for (i = tcce_pkg::CELLS - tcce_pkg::COLUMNS; i < tcce_pkg::CELLS; i++)
              cells[i] = attr_cell(tcce_pkg::CH_SPACE);
            row = tcce_pkg::ROWS - 1;
            r.scrolled = 1'b1;
          end
        end
        tcce_pkg::KIND_READ: begin
          if (idx < tcce_pkg::CELLS) r.cell_data = cells[idx];
        end
        tcce_pkg::KIND_CLEAR: blank_screen();
        default: ;
      endcase
      r.cursor_pos = tcce_pkg::CPOS_W'(row * tcce_pkg::COLUMNS + col);
      pending.push_back(r);
    endfunction

    function void note_failure(string what, report_t want, report_t got);
      failures++;
      if (failures <= MAX_SHOWN)
        $display("%0t %0s: expected pos %0d data %h scrolled %b, got pos %0d data %h scrolled %b",
                 $realtime, what, want.cursor_pos, want.cell_data, want.scrolled,
                 got.cursor_pos, got.cell_data, got.scrolled);
    endfunction

    function void check_result(report_t got);
      report_t want;
      if (pending.size() == 0) begin
        note_failure("result with none pending", '0, got);
        return;
      end
      want = pending.pop_front();
      if (got.cursor_pos !== want.cursor_pos || got.cell_data !== want.cell_data ||
          got.scrolled !== want.scrolled)
        note_failure("result mismatch", want, got);
    endfunction
  endclass

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_SLOW} rx_mode_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tcce_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [23:0]                    s_tdata = '0;   // char_code [7:0], cell_index [18:8]
  logic [1:0]                     s_tuser = '0;   // kind [1:0]
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [31:0]                    m_tdata;        // cursor_pos [10:0], cell_data [26:11]
  logic [0:0]                     m_tuser;        // scrolled [0]

  console_scoreboard sb = new();
  int burst_left = 0;
  int items_sent = 0;
  logic [7:0] rx_tick = '0;
  rx_mode_t rx_mode = RX_OPEN;

  text_console_cursor_engine uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // result side: check accepted items, stall on a changing pattern
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result('{cursor_pos: m_tdata[10:0], cell_data: m_tdata[26:11],
                        scrolled: m_tuser[0]});
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick[5:0] == 6'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= (rx_tick[1:0] == 2'd0);
      default:   m_tready <= rx_tick[3];
    endcase
  end

  // send one item, in bursts separated by random gaps
  task automatic send_item(input logic [tcce_pkg::KIND_W-1:0] kind,
                           input logic [tcce_pkg::CHAR_W-1:0] ch,
                           input logic [tcce_pkg::IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'd0, idx, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.apply_item(kind, ch, idx);
    burst_left--;
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  task automatic put_char(input logic [tcce_pkg::CHAR_W-1:0] ch);
    send_item(tcce_pkg::KIND_PUT, ch, tcce_pkg::IDX_W'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input int idx);
    send_item(tcce_pkg::KIND_READ, tcce_pkg::CHAR_W'($urandom_range(0, 255)),
              tcce_pkg::IDX_W'(idx));
  endtask

  // stop sending and let every owed result come back
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tcce_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tcce_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // a line of text, then usually a line end
  task automatic send_text_line();
    int len;
    int sel;
    int k;
    logic [tcce_pkg::CHAR_W-1:0] ch;
    sel = $urandom_range(0, 99);
    if (sel < 70) len = $urandom_range(0, 6);
    else if (sel < 90) len = $urandom_range(7, 30);
    else len = $urandom_range(60, 100);
    for (k = 0; k < len; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) ch = tcce_pkg::CHAR_W'($urandom_range(8'h20, 8'h7e));
      else if (sel < 88) ch = tcce_pkg::CHAR_W'($urandom_range(0, 255));
      else if (sel < 94) ch = tcce_pkg::CH_TAB;
      else ch = tcce_pkg::CH_BS;
      put_char(ch);
    end
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      put_char(tcce_pkg::CH_LF);
    end else if (sel < 85) begin
      put_char(tcce_pkg::CH_CR);
      put_char(tcce_pkg::CH_LF);
    end
  endtask

  initial begin
    int phase;
    int sel;
    int k;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset contents and reads past the store
    read_cell(0);
    read_cell(tcce_pkg::CELLS - 1);
    read_cell(tcce_pkg::CELLS);
    read_cell(2047);
    // backspace in column zero does nothing
    put_char(tcce_pkg::CH_BS);
    put_char(8'h00);
    put_char(8'hff);
    put_char(8'h41);
    put_char(tcce_pkg::CH_BS);
    read_cell(1);
    read_cell(2);
    put_char(tcce_pkg::CH_TAB);
    put_char(tcce_pkg::CH_CR);
    put_char(tcce_pkg::CH_LF);
    send_item(KIND_UNUSED, 8'hff, 11'h7ff);
    // brightest colors, then clear in them
    drain();
    write_reg(tcce_pkg::REG_FG, 4'hf);
    write_reg(tcce_pkg::REG_BG, 4'hf);
    put_char(8'h7e);
    read_cell(tcce_pkg::COLUMNS);
    send_item(tcce_pkg::KIND_CLEAR, 8'h00, 11'h000);
    read_cell(0);
    read_cell(tcce_pkg::CELLS - 1);

    // random console traffic, a new color setting per phase
    for (phase = 0; phase < 7; phase++) begin
      drain();
      if (phase == 0) begin
        write_reg(tcce_pkg::REG_FG, 4'h0);
        write_reg(tcce_pkg::REG_BG, 4'h0);
      end else begin
        write_reg(tcce_pkg::REG_FG, tcce_pkg::CFG_W'($urandom_range(0, 15)));
        write_reg(tcce_pkg::REG_BG, tcce_pkg::CFG_W'($urandom_range(0, 15)));
      end
      items_sent = 0;
      while (items_sent < 35) begin
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          send_text_line();
        end else if (sel < 67) begin
          repeat ($urandom_range(1, 8)) put_char(tcce_pkg::CH_LF);
        end else if (sel < 77) begin
          repeat ($urandom_range(1, 11)) put_char(tcce_pkg::CH_TAB);
        end else if (sel < 92) begin
          for (k = $urandom_range(1, 4); k > 0; k--) begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
              read_cell(sb.row * tcce_pkg::COLUMNS + $urandom_range(0, tcce_pkg::COLUMNS - 1));
            else if (sel < 9) read_cell($urandom_range(0, tcce_pkg::CELLS - 1));
            else read_cell($urandom_range(tcce_pkg::CELLS, 2047));
          end
        end else if (sel < 94) begin
          send_item(tcce_pkg::KIND_CLEAR, tcce_pkg::CHAR_W'($urandom_range(0, 255)),
                    tcce_pkg::IDX_W'($urandom_range(0, 2047)));
        end else begin
          repeat ($urandom_range(1, 3))
            send_item(tcce_pkg::KIND_W'($urandom_range(0, 3)),
                      tcce_pkg::CHAR_W'($urandom_range(0, 255)),
                      tcce_pkg::IDX_W'($urandom_range(0, 2047)));
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.failures++;
      $display("%0d results never arrived", sb.pending.size());
    end
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
